// File: rtl/window_fetch_with_border_modes_assert.svh
// ----------------------------------------------------------------------------
// window fetch assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef WINDOW_FETCH_WITH_BORDER_MODES_ASSERT_SVH
`define WINDOW_FETCH_WITH_BORDER_MODES_ASSERT_SVH

// same-cycle implication
`define WFBM_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WFBM_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/wfbm_pkg.sv
// ----------------------------------------------------------------------------
// wfbm_pkg
// shared types, constants and helpers of the window fetch block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wfbm_pkg;

    localparam int COORD_W   = 6;
    localparam int SIZE_W    = 7;
    localparam int PIX_W     = 24;
    localparam int WIN_W     = 3;
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [SIZE_W-1:0] MAX_WIDTH  = 7'd64;
    localparam logic [SIZE_W-1:0] MAX_HEIGHT = 7'd64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SELECT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE      = 3'd4;

    // edge modes
    localparam logic [1:0] EDGE_WRAP   = 2'd0;
    localparam logic [1:0] EDGE_BLACK  = 2'd1;
    localparam logic [1:0] EDGE_CLAMP  = 2'd2;
    localparam logic [1:0] EDGE_DIRECT = 2'd3;

    // channels
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_LUMA  = 2'd3;

    // item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic       load;
        logic       mod_step;
        logic [2:0] bit_idx;
        logic       back_step;
        logic       issue;
        logic       wr;
    } wfbm_cmd_t;

    typedef struct packed {
        logic adv;
        logic last_elem;
    } wfbm_sts_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] max_v);
        logic [SIZE_W-1:0] res;
        begin
            if (v == '0)
                res = 7'd1;
            else if (v > max_v)
                res = max_v;
            else
                res = v;
            return res;
        end
    endfunction

    function automatic logic [7:0] pick_channel(input logic [PIX_W-1:0] rgb,
                                                input logic [1:0] sel);
        logic [12:0] luma;
        logic [7:0]  res;
        begin
            luma = 13'd11 * {5'd0, rgb[23:16]} + {1'b0, rgb[15:8], 4'd0}
                 + 13'd5 * {5'd0, rgb[7:0]};
            case (sel)
                CH_RED:   res = rgb[23:16];
                CH_GREEN: res = rgb[15:8];
                CH_BLUE:  res = rgb[7:0];
                default:  res = luma[12:5];
            endcase
            return res;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/wfbm_ctrl.sv
// ----------------------------------------------------------------------------
// wfbm_ctrl
// sequencer: item accept, start coordinate setup and window streaming
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wfbm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  logic [1:0]          half_size,
    input  wfbm_pkg::wfbm_sts_t sts,
    output wfbm_pkg::wfbm_cmd_t cmd
);
    import wfbm_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MOD    = 2'd1;
    localparam logic [1:0] ST_BACK   = 2'd2;
    localparam logic [1:0] ST_STREAM = 2'd3;

    localparam logic [2:0] MOD_LAST = 3'(COORD_W - 1);

    logic [1:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        cmd           = '0;
        cmd.wr        = accept && (op == OP_WRITE);
        cmd.load      = accept && (op == OP_FETCH);
        cmd.bit_idx   = MOD_LAST - step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (cmd.load)
                    state_next = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                step_next    = step_reg + 3'd1;
                if (step_reg == MOD_LAST)
                begin
                    step_next  = '0;
                    state_next = (half_size == 2'd0) ? ST_STREAM : ST_BACK;
                end
            end
            ST_BACK:
            begin
                cmd.back_step = 1'b1;
                step_next     = step_reg + 3'd1;
                if (step_reg[1:0] == half_size - 2'd1)
                begin
                    step_next  = '0;
                    state_next = ST_STREAM;
                end
            end
            ST_STREAM:
            begin
                cmd.issue = 1'b1;
                if (sts.adv && sts.last_elem)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/wfbm_dp.sv
// ----------------------------------------------------------------------------
// wfbm_dp
// pixel store, coordinate resolve, channel select and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wfbm_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  wfbm_pkg::wfbm_cmd_t cmd,
    output wfbm_pkg::wfbm_sts_t sts,
    input  logic [5:0]          pos_x,
    input  logic [5:0]          pos_y,
    input  logic [23:0]         pixel_rgb,
    input  logic [6:0]          image_width,
    input  logic [6:0]          image_height,
    input  logic [1:0]          edge_mode,
    input  logic [1:0]          channel_select,
    input  logic [1:0]          half_size,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          sample,
    output logic [2:0]          win_row,
    output logic [2:0]          win_col,
    output logic                last
);
    import wfbm_pkg::*;

    logic [SIZE_W-1:0]  w_eff, h_eff;
    logic [WIN_W-1:0]   side_m1;

    logic [COORD_W-1:0] cx_reg, cy_reg;
    logic [COORD_W-1:0] wx_reg, wx_next;
    logic [COORD_W-1:0] wy_reg, wy_next;
    logic [COORD_W-1:0] wy0_reg, wy0_next;
    logic [WIN_W-1:0]   i_reg, i_next;
    logic [WIN_W-1:0]   j_reg, j_next;

    logic [SIZE_W-1:0]  shx, shy, subx, suby;
    logic [COORD_W-1:0] wx_back, wy_back, wx_fwd, wy_fwd;
    logic [SIZE_W-1:0]  wx_inc, wy_inc;

    logic signed [7:0]  ux, uy;
    logic               x_lo, x_hi, y_lo, y_hi;
    logic [COORD_W-1:0] cl_x, cl_y, ax, ay;
    logic               zero;

    logic               adv, rd_en;
    logic [PIX_W-1:0]   mem [0:MEM_DEPTH-1];
    logic [PIX_W-1:0]   rd_reg;

    logic               meta_valid_reg;
    logic               meta_zero_reg, meta_last_reg;
    logic [WIN_W-1:0]   meta_row_reg, meta_col_reg;

    logic               out_valid_reg;
    logic [7:0]         sample_reg;
    logic [WIN_W-1:0]   row_reg, col_reg;
    logic               last_reg;

    assign w_eff   = clamp_size(image_width, MAX_WIDTH);
    assign h_eff   = clamp_size(image_height, MAX_HEIGHT);
    assign side_m1 = {half_size, 1'b0};

    assign adv           = !out_valid_reg || out_ready;
    assign rd_en         = cmd.issue && adv;
    assign sts.adv       = adv;
    assign sts.last_elem = (i_reg == side_m1) && (j_reg == side_m1);

    // one remainder bit per setup step: center mod size
    assign shx  = {wx_reg, cx_reg[cmd.bit_idx]};
    assign shy  = {wy_reg, cy_reg[cmd.bit_idx]};
    assign subx = (shx >= w_eff) ? shx - w_eff : shx;
    assign suby = (shy >= h_eff) ? shy - h_eff : shy;

    // wrapped coordinate steps
    assign wx_back = (wx_reg == '0) ? 6'(w_eff - 7'd1) : wx_reg - 6'd1;
    assign wy_back = (wy_reg == '0) ? 6'(h_eff - 7'd1) : wy_reg - 6'd1;
    assign wx_inc  = {1'b0, wx_reg} + 7'd1;
    assign wy_inc  = {1'b0, wy_reg} + 7'd1;
    assign wx_fwd  = (wx_inc == w_eff) ? '0 : wx_inc[5:0];
    assign wy_fwd  = (wy_inc == h_eff) ? '0 : wy_inc[5:0];

    always_comb
    begin
        wx_next  = wx_reg;
        wy_next  = wy_reg;
        wy0_next = wy0_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        if (cmd.load)
        begin
            wx_next  = '0;
            wy_next  = '0;
            wy0_next = '0;
            i_next   = '0;
            j_next   = '0;
        end
        else if (cmd.mod_step)
        begin
            wx_next  = subx[5:0];
            wy_next  = suby[5:0];
            wy0_next = suby[5:0];
        end
        else if (cmd.back_step)
        begin
            wx_next  = wx_back;
            wy_next  = wy_back;
            wy0_next = wy_back;
        end
        else if (rd_en)
        begin
            // inner order runs over y
            if (j_reg == side_m1)
            begin
                j_next  = '0;
                i_next  = i_reg + 3'd1;
                wx_next = wx_fwd;
                wy_next = wy0_reg;
            end
            else
            begin
                j_next  = j_reg + 3'd1;
                wy_next = wy_fwd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wx_reg  <= '0;
            wy_reg  <= '0;
            wy0_reg <= '0;
            i_reg   <= '0;
            j_reg   <= '0;
        end
        else
        begin
            wx_reg  <= wx_next;
            wy_reg  <= wy_next;
            wy0_reg <= wy0_next;
            i_reg   <= i_next;
            j_reg   <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg <= pos_x;
            cy_reg <= pos_y;
        end
    end

    // unwrapped window coordinate
    assign ux = signed'({2'b00, cx_reg}) - signed'({6'b000000, half_size})
              + signed'({5'b00000, i_reg});
    assign uy = signed'({2'b00, cy_reg}) - signed'({6'b000000, half_size})
              + signed'({5'b00000, j_reg});

    assign x_lo = ux[7];
    assign y_lo = uy[7];
    assign x_hi = !ux[7] && (ux[6:0] >= w_eff);
    assign y_hi = !uy[7] && (uy[6:0] >= h_eff);

    assign cl_x = x_lo ? '0 : (x_hi ? 6'(w_eff - 7'd1) : ux[5:0]);
    assign cl_y = y_lo ? '0 : (y_hi ? 6'(h_eff - 7'd1) : uy[5:0]);

    always_comb
    begin
        case (edge_mode)
            EDGE_WRAP:
            begin
                ax   = wx_reg;
                ay   = wy_reg;
                zero = 1'b0;
            end
            EDGE_CLAMP:
            begin
                ax   = cl_x;
                ay   = cl_y;
                zero = 1'b0;
            end
            default:
            begin
                ax   = ux[5:0];
                ay   = uy[5:0];
                zero = x_lo || x_hi || y_lo || y_hi;
            end
        endcase
    end

    // single port pixel store: writes only while idle, reads only while streaming
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
            mem[{pos_y, pos_x}] <= pixel_rgb;
        else if (rd_en)
            rd_reg <= mem[{ay, ax}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            meta_valid_reg <= cmd.issue;
            out_valid_reg  <= meta_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            meta_zero_reg <= zero;
            meta_row_reg  <= i_reg;
            meta_col_reg  <= j_reg;
            meta_last_reg <= sts.last_elem;
        end
        if (adv && meta_valid_reg)
        begin
            sample_reg <= meta_zero_reg ? 8'd0 : pick_channel(rd_reg, channel_select);
            row_reg    <= meta_row_reg;
            col_reg    <= meta_col_reg;
            last_reg   <= meta_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign win_row   = row_reg;
    assign win_col   = col_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// File: rtl/window_fetch_with_border_modes.sv
// ----------------------------------------------------------------------------
// window_fetch_with_border_modes
// pixel store with neighborhood window readout and edge handling
//
// channel   direction  handshake            payload
// in        input      in_valid / in_ready   op, pos_x, pos_y, pixel_rgb
// out       output     out_valid / out_ready sample, win_row, win_col, last
// cfg       input      cfg_we                cfg_index, cfg_data
//
// a fetch runs six remainder steps for the wrap start and h steps back, then reads
// one element per cycle from the single port pixel store while out is not stalled,
// each element passing the read register and the output register on its way to out
// reset clears control and config; the pixel store is not cleared
// a stall on out freezes the whole read pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "window_fetch_with_border_modes_assert.svh"

module window_fetch_with_border_modes (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [5:0]  pos_x,
    input  logic [5:0]  pos_y,
    input  logic [23:0] pixel_rgb,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  sample,
    output logic [2:0]  win_row,
    output logic [2:0]  win_col,
    output logic        last,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import wfbm_pkg::*;

    logic [6:0] image_width_reg;
    logic [6:0] image_height_reg;
    logic [1:0] edge_mode_reg;
    logic [1:0] channel_select_reg;
    logic [1:0] half_size_reg;

    wfbm_cmd_t cmd;
    wfbm_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= MAX_WIDTH;
            image_height_reg   <= MAX_HEIGHT;
            edge_mode_reg      <= EDGE_CLAMP;
            channel_select_reg <= CH_RED;
            half_size_reg      <= 2'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:    image_width_reg    <= cfg_data;
                REG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data;
                REG_EDGE_MODE:      edge_mode_reg      <= cfg_data[1:0];
                REG_CHANNEL_SELECT: channel_select_reg <= cfg_data[1:0];
                REG_HALF_SIZE:      half_size_reg      <= cfg_data[1:0];
                default:            ;
            endcase
        end
    end

    wfbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .half_size (half_size_reg),
        .sts       (sts),
        .cmd       (cmd)
    );

    wfbm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pixel_rgb      (pixel_rgb),
        .image_width    (image_width_reg),
        .image_height   (image_height_reg),
        .edge_mode      (edge_mode_reg),
        .channel_select (channel_select_reg),
        .half_size      (half_size_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample         (sample),
        .win_row        (win_row),
        .win_col        (win_col),
        .last           (last)
    );

    `WFBM_ASSERT_NOW(a_no_rw_clash, cmd.wr, !cmd.issue, "store write during window read")
    `WFBM_ASSERT_NOW(a_last_corner, out_valid && last, win_row == win_col,
                     "last word not on the window corner")
    `WFBM_ASSERT_NOW(a_index_range, out_valid,
                     (win_row <= {half_size_reg, 1'b0}) && (win_col <= {half_size_reg, 1'b0}),
                     "window index beyond window side")
    `WFBM_ASSERT_NXT(a_fetch_busy, in_valid && in_ready && op == OP_FETCH, !in_ready,
                     "input taken while a fetch is being set up")

endmodule

`default_nettype wire

// File: test/wfbm_checker.sv
// ----------------------------------------------------------------------------
// wfbm_checker
// watches the in, out and cfg ports of the window fetch block, keeps its own
// pixel image and register copy, works out every window element of a fetch
// and compares each result word against the oldest one still outstanding
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wfbm_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        op,
    input  logic [5:0]  pos_x,
    input  logic [5:0]  pos_y,
    input  logic [23:0] pixel_rgb,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  sample,
    input  logic [2:0]  win_row,
    input  logic [2:0]  win_col,
    input  logic        last,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    output int          errors,
    output int          pending
);

    import wfbm_pkg::*;

    typedef struct packed {
        logic [7:0] sample;
        logic [2:0] win_row;
        logic [2:0] win_col;
        logic       last;
    } window_elem_t;

    window_elem_t     window_q[$];
    logic [PIX_W-1:0] image_mem [0:MEM_DEPTH-1];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [1:0]       edge_reg;
    logic [1:0]       chan_reg;
    logic [1:0]       half_reg;
    int               err_cnt;

    function automatic int size_in_use(input logic [SIZE_W-1:0] raw, input int max_v);
        if (raw == '0)
            return 1;
        if (int'(raw) > max_v)
            return max_v;
        return int'(raw);
    endfunction

    // pixel seen at an image coordinate once the edge mode is applied
    function automatic logic [PIX_W-1:0] pixel_at(input int x, input int y);
        int w;
        int h;
        int rx;
        int ry;
        w = size_in_use(width_reg, int'(MAX_WIDTH));
        h = size_in_use(height_reg, int'(MAX_HEIGHT));
        rx = x;
        ry = y;
        case (edge_reg)
            EDGE_WRAP:
            begin
                rx = x % w;
                if (rx < 0)
                    rx += w;
                ry = y % h;
                if (ry < 0)
                    ry += h;
            end
            EDGE_CLAMP:
            begin
                rx = (x < 0) ? 0 : (x >= w) ? w - 1 : x;
                ry = (y < 0) ? 0 : (y >= h) ? h - 1 : y;
            end
            default:
            begin
                if (x < 0 || x >= w || y < 0 || y >= h)
                    return '0;
            end
        endcase
        return image_mem[ry * int'(MAX_WIDTH) + rx];
    endfunction

    function automatic logic [7:0] channel_of(input logic [PIX_W-1:0] rgb);
        int luma;
        luma = (11 * int'(rgb[23:16]) + 16 * int'(rgb[15:8]) + 5 * int'(rgb[7:0])) >> 5;
        case (chan_reg)
            CH_RED:   return rgb[23:16];
            CH_GREEN: return rgb[15:8];
            CH_BLUE:  return rgb[7:0];
            default:  return luma[7:0];
        endcase
    endfunction

    // outer loop over x, inner over y
    task automatic predict_window(input logic [5:0] cx, input logic [5:0] cy);
        int side;
        window_elem_t elem;
        side = 2 * int'(half_reg) + 1;
        for (int i = 0; i < side; i++) begin
            for (int j = 0; j < side; j++) begin
                elem.sample  = channel_of(pixel_at(int'(cx) - int'(half_reg) + i,
                                                   int'(cy) - int'(half_reg) + j));
                elem.win_row = i[2:0];
                elem.win_col = j[2:0];
                elem.last    = (i == side - 1) && (j == side - 1);
                window_q.push_back(elem);
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        window_elem_t want;
        if (!rst_n) begin
            width_reg  = MAX_WIDTH;
            height_reg = MAX_HEIGHT;
            edge_reg   = EDGE_CLAMP;
            chan_reg   = CH_RED;
            half_reg   = 2'd1;
            window_q.delete();
            err_cnt    = 0;
            errors  <= 0;
            pending <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (window_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result word, expected none, actual sample %0d row %0d col %0d last %0d",
                             $time, sample, win_row, win_col, last);
                end
                else begin
                    want = window_q.pop_front();
                    check_field("sample", want.sample, sample);
                    check_field("win_row", want.win_row, win_row);
                    check_field("win_col", want.win_col, win_col);
                    check_field("last", want.last, last);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:    width_reg  = cfg_data;
                    REG_IMAGE_HEIGHT:   height_reg = cfg_data;
                    REG_EDGE_MODE:      edge_reg   = cfg_data[1:0];
                    REG_CHANNEL_SELECT: chan_reg   = cfg_data[1:0];
                    REG_HALF_SIZE:      half_reg   = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                if (op == OP_WRITE)
                    image_mem[{pos_y, pos_x}] = pixel_rgb;
                else
                    predict_window(pos_x, pos_y);
            end
            errors  <= err_cnt;
            pending <= window_q.size();
        end
    end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// window fetch block: corner and edge-mode fetches first, then random phases
// of pixel writes and window fetches under changing image size, edge mode,
// channel and radius, with random stalls on both channels in early phases;
// each unwritten pixel that a fetch uses is written before it is read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import wfbm_pkg::*;

    localparam int NUM_PHASES      = 12;
    localparam int WORDS_PER_PHASE = 20;
    localparam int SETTLE_CYCLES   = 64;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_HALF_SIZE + 3'd1;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        op        = OP_WRITE;
    logic [5:0]  pos_x     = '0;
    logic [5:0]  pos_y     = '0;
    logic [23:0] pixel_rgb = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  sample;
    logic [2:0]  win_row;
    logic [2:0]  win_col;
    logic        last;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [6:0]  cfg_data  = '0;

    int errors;
    int pending;
    int send_idle = 31;
    int recv_idle = 45;

    // settings in force, used to decide which pixels a fetch will touch
    int         cur_w    = 64;
    int         cur_h    = 64;
    logic [1:0] cur_mode = EDGE_CLAMP;
    int         cur_half = 1;
    bit         written [0:MEM_DEPTH-1];

    window_fetch_with_border_modes dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pixel_rgb (pixel_rgb),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample),
        .win_row   (win_row),
        .win_col   (win_col),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wfbm_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pixel_rgb (pixel_rgb),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample),
        .win_row   (win_row),
        .win_col   (win_col),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // store column or row actually read for one axis; zero means nothing read
    function automatic bit resolve_axis(input int c, input int n, output int idx);
        idx = c;
        case (cur_mode)
            EDGE_WRAP:
            begin
                idx = c % n;
                if (idx < 0)
                    idx += n;
            end
            EDGE_CLAMP:
                idx = (c < 0) ? 0 : (c >= n) ? n - 1 : c;
            default:
                return (c >= 0 && c < n);
        endcase
        return 1'b1;
    endfunction

    task automatic send_word(input logic o, input logic [5:0] x, input logic [5:0] y,
                             input logic [23:0] rgb);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= o;
        pos_x     <= x;
        pos_y     <= y;
        pixel_rgb <= rgb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (o == OP_WRITE)
            written[{y, x}] = 1'b1;
    endtask

    task automatic fetch_window(input logic [5:0] cx, input logic [5:0] cy);
        int  side;
        int  rx;
        int  ry;
        bit  okx;
        bit  oky;
        side = 2 * cur_half + 1;
        for (int i = 0; i < side; i++) begin
            for (int j = 0; j < side; j++) begin
                okx = resolve_axis(int'(cx) - cur_half + i, cur_w, rx);
                oky = resolve_axis(int'(cy) - cur_half + j, cur_h, ry);
                if (okx && oky && !written[{ry[5:0], rx[5:0]}])
                    send_word(OP_WRITE, rx[5:0], ry[5:0], $urandom);
            end
        end
        send_word(OP_FETCH, cx, cy, $urandom);
    endtask

    task automatic wait_for_results(input bit settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [6:0] w_raw, input logic [6:0] h_raw,
                              input logic [1:0] mode, input logic [1:0] chan,
                              input logic [1:0] half);
        logic [4:0] upper;
        logic [2:0] spare;
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= w_raw;
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= h_raw;
        @(posedge clk);
        upper = $urandom;
        cfg_index <= REG_EDGE_MODE;
        cfg_data  <= {upper, mode};
        @(posedge clk);
        upper = $urandom;
        cfg_index <= REG_CHANNEL_SELECT;
        cfg_data  <= {upper, chan};
        @(posedge clk);
        upper = $urandom;
        cfg_index <= REG_HALF_SIZE;
        cfg_data  <= {upper, half};
        @(posedge clk);
        // unused index, must change nothing
        spare = $urandom_range(2);
        cfg_index <= REG_FIRST_UNUSED + spare;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_w    = (w_raw == '0) ? 1 : (w_raw > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(w_raw);
        cur_h    = (h_raw == '0) ? 1 : (h_raw > MAX_HEIGHT) ? int'(MAX_HEIGHT) : int'(h_raw);
        cur_mode = mode;
        cur_half = half;
    endtask

    task automatic random_word();
        int         pick;
        logic [5:0] cx;
        logic [5:0] cy;
        pick = $urandom_range(99);
        // now and then hold off until the block has drained
        if (pick < 3)
            wait_for_results(1'b0);
        if (pick < 65) begin
            if (pick % 2 == 0) begin
                cx = $urandom;
                cy = $urandom;
            end
            else begin
                cx = $urandom_range(cur_w + cur_half);
                cy = $urandom_range(cur_h + cur_half);
            end
            fetch_window(cx, cy);
        end
        else if (pick < 85)
            send_word(OP_WRITE, $urandom_range(cur_w - 1), $urandom_range(cur_h - 1), $urandom);
        else
            send_word(OP_WRITE, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [6:0] w_raw;
        logic [6:0] h_raw;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: clamp, red, radius one, full image
        send_word(OP_WRITE, 6'd0, 6'd0, 24'hFFFFFF);
        send_word(OP_WRITE, 6'd63, 6'd63, 24'h000000);
        fetch_window(6'd0, 6'd0);
        fetch_window(6'd63, 6'd63);

        // wrap around the top left corner, luma of white
        wait_for_results(1'b1);
        set_config(7'd64, 7'd64, EDGE_WRAP, CH_LUMA, 2'd1);
        fetch_window(6'd0, 6'd0);

        // single element window at the right edge
        wait_for_results(1'b1);
        set_config(7'd64, 7'd64, EDGE_BLACK, CH_GREEN, 2'd0);
        fetch_window(6'd63, 6'd0);

        // window hanging off the bottom edge
        wait_for_results(1'b1);
        set_config(7'd64, 7'd64, EDGE_DIRECT, CH_BLUE, 2'd1);
        fetch_window(6'd0, 6'd63);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES / 3) begin
                send_idle = 45;
                recv_idle <= 31;
            end
            if (p == 2 * NUM_PHASES / 3) begin
                send_idle = 0;
                recv_idle <= 0;
            end
            // wide strip keeps the number of pixels to fill small
            if ($urandom_range(3) == 0) begin
                w_raw = $urandom;
                h_raw = $urandom_range(0, 2);
            end
            else begin
                w_raw = $urandom_range(1, 10);
                h_raw = $urandom_range(1, 10);
            end
            // out of range sizes get saturated, and phase 5 takes the full width with one row
            case (p)
                1:
                begin
                    w_raw = 7'd0;
                    h_raw = 7'd127;
                end
                5:
                begin
                    w_raw = 7'd64;
                    h_raw = 7'd1;
                end
                9:
                begin
                    w_raw = 7'd127;
                    h_raw = 7'd0;
                end
                default: ;
            endcase
            wait_for_results(1'b1);
            set_config(w_raw, h_raw, p % 4, (p + p / 4) % 4, (p / 3) % 4);
            repeat (WORDS_PER_PHASE) random_word();
        end

        wait_for_results(1'b1);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
